// ----- hw/rtl/crdo_pkg.sv -----
package crdo_pkg;

  localparam int STORE_DEPTH  = 31;
  localparam int EL_W         = 5;
  localparam int RANK_W       = 29;
  localparam int UNIVERSE_DEF = 31;
  localparam int BINOM_DEPTH  = 1 << (2 * EL_W);

  typedef logic [RANK_W-1:0] rank_t;
  typedef logic [BINOM_DEPTH-1:0][RANK_W-1:0] binom_tab_t;

  typedef struct packed {
    logic            we;
    logic [EL_W-1:0] waddr;
    logic            clr;
    logic            add_b;
    logic            emit;
    logic            last;
    logic [EL_W-1:0] p;
    logic [EL_W-1:0] size;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

  // Pascal triangle, index {n, k}; zero where k exceeds n.
  function automatic binom_tab_t build_binom();
    binom_tab_t t;
    for (int n = 0; n < (1 << EL_W); n++) begin
      for (int k = 0; k < (1 << EL_W); k++) begin
        if (k == 0) begin
          t[n * (1 << EL_W) + k] = rank_t'(1);
        end else if (n == 0) begin
          t[n * (1 << EL_W) + k] = '0;
        end else begin
          t[n * (1 << EL_W) + k] = t[(n - 1) * (1 << EL_W) + k - 1]
                                 + t[(n - 1) * (1 << EL_W) + k];
        end
      end
    end
    return t;
  endfunction

  localparam binom_tab_t BINOM = build_binom();

endpackage

// ----- hw/rtl/crdo_ctrl.sv -----
module crdo_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [crdo_pkg::EL_W-1:0] set_size,
  input  crdo_pkg::sts_t            sts,
  output crdo_pkg::cmd_t            cmd
);
  import crdo_pkg::*;

  typedef enum logic [3:0] {
    S_LOAD = 4'b0001,
    S_RD   = 4'b0010,
    S_LK   = 4'b0100,
    S_AC   = 4'b1000
  } state_t;

  state_t          state, state_next;
  logic [EL_W-1:0] load_count, load_count_next;
  logic [EL_W-1:0] p, p_next;
  logic [EL_W-1:0] size_q, size_q_next;
  logic            rank_phase, rank_phase_next;
  logic [EL_W-1:0] size_eff;
  logic [EL_W-1:0] count_inc;

  assign size_eff  = (set_size == '0) ? EL_W'(1) : set_size;
  assign count_inc = EL_W'(load_count + 1'b1);
  assign in_ready  = (state == S_LOAD);

  always_comb begin
    state_next      = state;
    load_count_next = load_count;
    p_next          = p;
    size_q_next     = size_q;
    rank_phase_next = rank_phase;
    cmd             = '0;
    cmd.waddr       = load_count;
    cmd.p           = p;
    cmd.size        = size_q;
    case (state)
      S_LOAD: begin
        if (in_valid) begin
          cmd.we = 1'b1;
          if (count_inc >= size_eff) begin
            cmd.clr         = 1'b1;
            load_count_next = '0;
            p_next          = EL_W'(1);
            size_q_next     = size_eff;
            rank_phase_next = 1'b0;
            state_next      = S_RD;
          end else begin
            load_count_next = count_inc;
          end
        end
      end
      S_RD: state_next = S_LK;
      S_LK: state_next = S_AC;
      S_AC: begin
        if (!rank_phase) begin
          cmd.add_b  = 1'b1;
          state_next = S_RD;
          if (p == size_q) begin
            rank_phase_next = 1'b1;
            p_next          = EL_W'(1);
          end else begin
            p_next = EL_W'(p + 1'b1);
          end
        end else if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.last = (p == size_q);
          if (p == size_q) begin
            state_next = S_LOAD;
          end else begin
            p_next     = EL_W'(p + 1'b1);
            state_next = S_RD;
          end
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      load_count <= '0;
      p          <= EL_W'(1);
      size_q     <= EL_W'(1);
      rank_phase <= 1'b0;
    end else begin
      state      <= state_next;
      load_count <= load_count_next;
      p          <= p_next;
      size_q     <= size_q_next;
      rank_phase <= rank_phase_next;
    end
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> sts.out_free) else $error("result emitted into a full output register");

  a_p_range: assert property (@(posedge clk) disable iff (rst)
    (state != S_LOAD) |-> (p != '0 && p <= size_q)) else $error("position out of range");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    load_count < EL_W'(STORE_DEPTH)) else $error("load count past store depth");

  a_last_done: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && cmd.last) |=> (state == S_LOAD)) else $error("no return to load");

endmodule

// ----- hw/rtl/crdo_dp.sv -----
module crdo_dp #(
  parameter int UNIVERSE = crdo_pkg::UNIVERSE_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [crdo_pkg::EL_W-1:0]   element,
  input  crdo_pkg::cmd_t              cmd,
  output crdo_pkg::sts_t              sts,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [crdo_pkg::RANK_W-1:0] out_rank,
  output logic [crdo_pkg::EL_W-1:0]   out_pos,
  output logic                        out_last
);
  import crdo_pkg::*;

  logic [EL_W-1:0] mem [STORE_DEPTH];
  logic [EL_W-1:0] el_sat;
  logic [EL_W-1:0] rd_addr;
  logic [EL_W-1:0] store_q;
  logic [EL_W-1:0] k_a, k_b;
  rank_t           a_q, b_q;
  rank_t           pref_a, suf_b;
  rank_t           suf_rest;

  assign el_sat   = (element >= EL_W'(UNIVERSE)) ? EL_W'(UNIVERSE - 1) : element;
  assign rd_addr  = EL_W'(cmd.p - 1'b1);
  assign k_a      = EL_W'(cmd.size - cmd.p);
  assign k_b      = EL_W'(cmd.size - cmd.p + 1'b1);
  assign suf_rest = suf_b - b_q;
  assign sts.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[cmd.waddr] <= el_sat;
    end
    store_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    a_q <= BINOM[{store_q, k_a}];
    b_q <= BINOM[{store_q, k_b}];
  end

  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      pref_a <= '0;
      suf_b  <= '0;
    end else if (cmd.add_b) begin
      suf_b <= suf_b + b_q;
    end else if (cmd.emit) begin
      suf_b  <= suf_rest;
      pref_a <= pref_a + a_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_rank <= pref_a + suf_rest;
      out_pos  <= cmd.p;
      out_last <= cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ----- hw/rtl/combination_rank_drop_one.sv -----
// Combination rank with one element dropped.
// Slave stream: one element per transfer in s_tdata[4:0], strictly decreasing.
// After set_size elements, the master stream gives set_size transfers, one per
// position p = 1..set_size: the combinadic rank of the combination without
// element p, with p alongside and m_tlast on the final position.
// APB register 0 (set_size, 5 bits, reset 5; 0 acts as 1): the user must write
// it only between combinations; the block itself does not enforce this.
// Elements are taken one per cycle while loading; s_tready is low from the
// final element until the final result sits in the output register.
// A run of n elements first passes over the element store and Pascal table
// ROM to sum, then passes again to give one result per position; each
// position goes through the read, lookup and accumulate states. A stalled
// receiver holds the output register and the sequencer waits on it.
// Reset clears the load count, the sequencer and the output valid; stored
// elements keep their contents.
module combination_rank_drop_one #(
  parameter int UNIVERSE = crdo_pkg::UNIVERSE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [4:0] element
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [28:0] rank, [33:29] omitted_position
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import crdo_pkg::*;

  logic [EL_W-1:0]   set_size;
  cmd_t              cmd;
  sts_t              sts;
  logic [RANK_W-1:0] out_rank;
  logic [EL_W-1:0]   out_pos;

  assign pready = 1'b1;
  assign prdata = {{(32 - EL_W){1'b0}}, set_size};

  always_ff @(posedge clk) begin
    if (rst) begin
      set_size <= EL_W'(5);
    end else if (psel && penable && pwrite && pready && paddr[1] == 1'b0) begin
      set_size <= pwdata[EL_W-1:0];
    end
  end

  crdo_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .set_size (set_size),
    .sts      (sts),
    .cmd      (cmd)
  );

  crdo_dp #(
    .UNIVERSE (UNIVERSE)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .element   (s_tdata[EL_W-1:0]),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_rank  (out_rank),
    .out_pos   (out_pos),
    .out_last  (m_tlast)
  );

  assign m_tdata = {{(40 - RANK_W - EL_W){1'b0}}, out_pos, out_rank};

endmodule

// ----- dv/combination_rank_drop_one_test.sv -----
module combination_rank_drop_one_test;
  timeunit 1ns;
  timeprecision 1ps;

  import crdo_pkg::*;

  localparam logic [1:0] SET_SIZE_ADDR = 2'd0;
  localparam int RESET_SIZE   = 5;
  localparam int DRAIN_CYCLES = 6 * STORE_DEPTH + 20;
  localparam int STALL_LIMIT  = 4000;
  localparam int RANDOM_ITEMS = 250;
  localparam int MAX_GAP      = 11;
  localparam int MAX_PRINTS   = 40;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;    // [4:0] element
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;         // [28:0] rank, [33:29] omitted_position
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  combination_rank_drop_one dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  typedef struct {
    rank_t           rank;
    logic [EL_W-1:0] pos;
    logic            last;
  } drop_rank_t;

  drop_rank_t      ranks_due[$];
  logic [EL_W-1:0] elems[STORE_DEPTH];
  int unsigned     loaded = 0;
  logic [4:0]      size_reg = 5'(RESET_SIZE);
  int              errors = 0;
  int              items_sent = 0;
  int              stall_cycles = 0;
  bit              tx_gaps = 1'b1;
  bit              rx_gaps = 1'b1;

  function automatic longint unsigned choose_nk(int n, int k);
    longint unsigned r;
    r = 1;
    if (k > n) return 0;
    if (k > n - k) k = n - k;
    for (int i = 0; i < k; i++) r = r * longint'(n - i) / longint'(i + 1);
    return r;
  endfunction

  function automatic void predict_element(logic [EL_W-1:0] raw);
    int unsigned     sz;
    int unsigned     cnt;
    logic [EL_W-1:0] e;
    longint unsigned acc;
    drop_rank_t      r;
    sz = (size_reg == 0) ? 1 : size_reg;
    e = (raw >= UNIVERSE_DEF) ? EL_W'(UNIVERSE_DEF - 1) : raw;
    cnt = loaded;
    if (cnt >= STORE_DEPTH) cnt = STORE_DEPTH - 1;
    elems[cnt] = e;
    cnt++;
    if (cnt < sz) begin
      loaded = cnt;
      return;
    end
    loaded = 0;
    for (int p = 1; p <= sz; p++) begin
      acc = 0;
      for (int i = 1; i <= sz; i++) begin
        if (i < p) begin
          acc += choose_nk(elems[i-1], sz - i);
        end else if (i > p) begin
          acc += choose_nk(elems[i-1], sz - i + 1);
        end
      end
      r.rank = rank_t'(acc);
      r.pos  = EL_W'(p);
      r.last = (p == sz);
      ranks_due.push_back(r);
    end
  endfunction

  task automatic report_mismatch(string msg);
    errors++;
    if (errors <= MAX_PRINTS) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  // result checker
  always @(posedge clk) begin
    drop_rank_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      if (ranks_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result rank=%0d pos=%0d",
                                  m_tdata[28:0], m_tdata[33:29]));
      end else begin
        exp_r = ranks_due.pop_front();
        if (m_tdata[28:0] !== exp_r.rank)
          report_mismatch($sformatf("pos %0d rank %0d, expected %0d",
                                    exp_r.pos, m_tdata[28:0], exp_r.rank));
        if (m_tdata[33:29] !== exp_r.pos)
          report_mismatch($sformatf("omitted_position %0d, expected %0d",
                                    m_tdata[33:29], exp_r.pos));
        if (m_tlast !== exp_r.last)
          report_mismatch($sformatf("pos %0d tlast %0b, expected %0b",
                                    exp_r.pos, m_tlast, exp_r.last));
      end
    end
  end

  // receiver backpressure
  initial begin
    int gap;
    forever begin
      gap = rx_gaps ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (psel && penable && pready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic send_element(logic [EL_W-1:0] e);
    int gap;
    gap = tx_gaps ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, e};
    do @(posedge clk); while (!s_tready);
    predict_element(e);
    items_sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (ranks_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_check();
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    paddr   <= SET_SIZE_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[4:0] !== size_reg)
      report_mismatch($sformatf("set_size reads %0d, expected %0d", prdata[4:0], size_reg));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic cfg_write(logic [31:0] word);
    drain();
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= SET_SIZE_ADDR;
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    size_reg = word[4:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    cfg_check();
  endtask

  // strictly decreasing random combination, selection sampling from the top
  task automatic load_combination(int sz);
    int need;
    need = (sz == 0) ? 1 : sz;
    for (int v = UNIVERSE_DEF - 1; v >= 0 && need > 0; v--) begin
      if ($urandom_range(0, v) < need) begin
        send_element(EL_W'(v));
        need--;
      end
    end
  endtask

  function automatic int pick_size();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 0;
    if (r <= 2) return $urandom_range(9, STORE_DEPTH);
    return $urandom_range(1, 8);
  endfunction

  task automatic test_reset_value();
    cfg_check();
    load_combination(RESET_SIZE);
  endtask

  // fills every store position, largest size
  task automatic test_full_size();
    cfg_write(32'(STORE_DEPTH));
    for (int v = UNIVERSE_DEF - 1; v >= 0; v--) send_element(EL_W'(v));
  endtask

  task automatic test_single_and_zero_size();
    cfg_write(32'd1);
    send_element(5'd0);
    send_element(5'd30);
    cfg_write(32'd0);
    send_element(5'd31);
    send_element(5'd5);
  endtask

  task automatic test_pair();
    cfg_write(32'd2);
    send_element(5'd30);
    send_element(5'd29);
    send_element(5'd1);
    send_element(5'd0);
  endtask

  // repeated top element, sum wraps past 29 bits
  task automatic test_rank_wrap();
    cfg_write(32'd16);
    repeat (16) send_element(5'd30);
  endtask

  task automatic test_size_lowered();
    cfg_write(32'd10);
    send_element(5'd20);
    send_element(5'd15);
    send_element(5'd10);
    send_element(5'd5);
    cfg_write(32'd3);
    send_element(5'd2);
  endtask

  task automatic test_size_raised();
    cfg_write(32'd3);
    send_element(5'd25);
    send_element(5'd12);
    cfg_write(32'd6);
    send_element(5'd9);
    send_element(5'd7);
    send_element(5'd3);
    send_element(5'd1);
  endtask

  task automatic test_random();
    int          stop_at;
    int          sz;
    int          n;
    int          kind;
    logic [31:0] word;
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      tx_gaps = ($urandom_range(0, 3) != 0);
      rx_gaps = ($urandom_range(0, 3) != 0);
      sz = pick_size();
      if (sz != size_reg || $urandom_range(0, 7) == 0) begin
        word = $urandom();
        word[4:0] = 5'(sz);
        cfg_write(word);
      end
      n = (sz == 0) ? 1 : sz;
      kind = $urandom_range(0, 9);
      if (kind < 7 || (kind == 9 && n == 1)) begin
        load_combination(sz);
      end else if (kind < 9) begin
        repeat (n) send_element(EL_W'($urandom_range(0, 31)));
      end else begin
        repeat ($urandom_range(1, n - 1)) send_element(EL_W'($urandom_range(0, 31)));
        word = $urandom();
        word[4:0] = 5'($urandom_range(1, STORE_DEPTH));
        cfg_write(word);
        do send_element(EL_W'($urandom_range(0, 31))); while (loaded != 0);
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_value();
    test_full_size();
    test_single_and_zero_size();
    test_pair();
    test_rank_wrap();
    test_size_lowered();
    test_size_raised();
    test_random();
    drain();
    if (errors == 0 && ranks_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/crdo_pkg.sv
hw/rtl/crdo_ctrl.sv
hw/rtl/crdo_dp.sv
hw/rtl/combination_rank_drop_one.sv
dv/combination_rank_drop_one_test.sv
